### hdl/rwpo_pkg.sv
// Shared types, constants and the control store for the random-walk OHLC block.
// Used by the sequencer, the datapath, the candle tracker and the top level.
package rwpo_pkg;

  localparam int unsigned EXP_FRAC = 28;
  localparam logic signed [29:0] EXP_ONE = 30'sd268435456;
  localparam logic signed [63:0] CLAMP_Q28 = 64'sd26843546;
  localparam logic signed [63:0] ROUND_HALF = 64'sd134217728;
  localparam logic [2:0] HORNER_TERMS = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_INITIAL_PRICE = 2'd0;
  localparam logic [1:0] CFG_STEP_SCALE = 2'd1;
  localparam logic [1:0] CFG_TICKS_PER_CANDLE = 2'd2;

  // step codes of the control program
  typedef logic [2:0] step_t;
  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_MUL_X = 3'd1;
  localparam step_t STEP_CLAMP = 3'd2;
  localparam step_t STEP_MUL_XT = 3'd3;
  localparam step_t STEP_MUL_DIV = 3'd4;
  localparam step_t STEP_T_UPD = 3'd5;
  localparam step_t STEP_MUL_P = 3'd6;
  localparam step_t STEP_COMMIT = 3'd7;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_X,
    MUL_XT,
    MUL_DIV,
    MUL_PRICE
  } mul_sel_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_LOOP,
    JMP_DONE
  } jump_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     ld_x;
    logic     ld_t;
    logic     ld_price;
    jump_e    jump;
    step_t    target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    mul_sel_e mul_sel;
    logic     ld_x;
    logic     ld_t;
    logic     take_in;
    logic     commit;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic k_last;
  } dp_status_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{mul_sel: MUL_NONE, ld_x: 1'b0, ld_t: 1'b0, ld_price: 1'b0,
          jump: JMP_NEXT, target: STEP_IDLE};
    unique case (s)
      STEP_IDLE:    w.jump = JMP_WAIT_IN;
      STEP_MUL_X:   w.mul_sel = MUL_X;
      STEP_CLAMP:   w.ld_x = 1'b1;
      STEP_MUL_XT:  w.mul_sel = MUL_XT;
      STEP_MUL_DIV: w.mul_sel = MUL_DIV;
      STEP_T_UPD: begin
        w.ld_t = 1'b1;
        w.jump = JMP_LOOP;
        w.target = STEP_MUL_XT;
      end
      STEP_MUL_P:   w.mul_sel = MUL_PRICE;
      STEP_COMMIT: begin
        w.ld_price = 1'b1;
        w.jump = JMP_DONE;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // ceil(2^28 / k), exact for truncating division of a 26-bit magnitude
  function automatic logic [28:0] recip(logic [2:0] k);
    logic [28:0] r;
    case (k)
      3'd2:    r = 29'd134217728;
      3'd3:    r = 29'd89478486;
      3'd4:    r = 29'd67108864;
      3'd5:    r = 29'd53687092;
      3'd6:    r = 29'd44739243;
      default: r = 29'd268435456;
    endcase
    return r;
  endfunction

endpackage

### hdl/rwpo_sequencer.sv
// Step counter and control-store decode for the random-walk OHLC block.
// Depends on rwpo_pkg for the program, control word and status types.
module rwpo_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_free_i,
  input  rwpo_pkg::dp_status_t status_i,
  output logic                in_stall_o,
  output rwpo_pkg::ctrl_t     ctrl_o
);
  import rwpo_pkg::*;

  step_t  step_q, step_d;
  uword_t uw;

  assign uw = ucode(step_q);
  assign in_stall_o = (uw.jump != JMP_WAIT_IN);

  assign ctrl_o.mul_sel = uw.mul_sel;
  assign ctrl_o.ld_x = uw.ld_x;
  assign ctrl_o.ld_t = uw.ld_t;
  assign ctrl_o.take_in = (uw.jump == JMP_WAIT_IN) && in_valid_i;
  assign ctrl_o.commit = uw.ld_price && out_free_i;

  always_comb begin
    step_d = step_q;
    unique case (uw.jump)
      JMP_NEXT:    step_d = step_q + 3'd1;
      JMP_WAIT_IN: if (in_valid_i) step_d = step_q + 3'd1;
      JMP_LOOP:    step_d = status_i.k_last ? step_q + 3'd1 : uw.target;
      JMP_DONE:    if (out_free_i) step_d = uw.target;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### hdl/rwpo_datapath.sv
// Shared multiplier datapath: step scaling, clamp, exp Horner loop, price update.
// Depends on rwpo_pkg for the control word, constants and reciprocal table.
module rwpo_datapath #(
  parameter logic [31:0] PRICE_FLOOR = 32'd655
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rwpo_pkg::ctrl_t      ctrl_i,
  input  logic signed [15:0]   normal_sample_i,
  input  logic [31:0]          initial_price_i,
  input  logic [16:0]          step_scale_i,
  output rwpo_pkg::dp_status_t status_o,
  output logic [31:0]          price_o
);
  import rwpo_pkg::*;

  logic               started_q;
  logic [31:0]        price_q;
  logic signed [15:0] sample_q;
  logic signed [63:0] prod_q, prod_d;
  logic signed [25:0] x_q, x_d;
  logic signed [29:0] t_q, t_d;
  logic [2:0]         k_q;
  logic               neg_q;

  logic signed [33:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [26:0] f_s, f_neg;
  logic [25:0]        mag;
  logic signed [29:0] q_s;
  logic signed [63:0] rnd;
  logic [35:0]        p_full;

  // floor of the Q28 product, then its magnitude for the truncating divide
  assign f_s = prod_q[54:28];
  assign f_neg = -f_s;
  assign mag = prod_q[63] ? f_neg[25:0] : f_s[25:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.mul_sel)
      MUL_X: begin
        mul_a = {{18{sample_q[15]}}, sample_q};
        mul_b = {13'd0, step_scale_i};
      end
      MUL_XT: begin
        mul_a = {{8{x_q[25]}}, x_q};
        mul_b = t_q;
      end
      MUL_DIV: begin
        mul_a = {8'd0, mag};
        mul_b = {1'b0, recip(k_q)};
      end
      MUL_PRICE: begin
        mul_a = {2'd0, price_q};
        mul_b = t_q;
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    if (prod_q > CLAMP_Q28) begin
      x_d = CLAMP_Q28[25:0];
    end else if (prod_q < -CLAMP_Q28) begin
      x_d = -(CLAMP_Q28[25:0]);
    end else begin
      x_d = prod_q[25:0];
    end
  end

  assign q_s = {4'd0, prod_q[53:28]};
  assign t_d = neg_q ? EXP_ONE - q_s : EXP_ONE + q_s;

  // round, saturate, floor
  assign rnd = prod_q + ROUND_HALF;
  assign p_full = rnd[63:28];
  always_comb begin
    if (|p_full[35:32]) begin
      price_o = 32'hFFFF_FFFF;
    end else if (p_full[31:0] < PRICE_FLOOR) begin
      price_o = PRICE_FLOOR;
    end else begin
      price_o = p_full[31:0];
    end
  end

  assign status_o.k_last = (k_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      price_q <= '0;
    end else begin
      if (ctrl_i.take_in && !started_q) begin
        started_q <= 1'b1;
        price_q <= initial_price_i;
      end else if (ctrl_i.commit) begin
        price_q <= price_o;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_in) sample_q <= normal_sample_i;
    if (ctrl_i.mul_sel != MUL_NONE) prod_q <= prod_d;
    if (ctrl_i.mul_sel == MUL_DIV) neg_q <= prod_q[63];
    if (ctrl_i.ld_x) begin
      x_q <= x_d;
      t_q <= EXP_ONE;
      k_q <= HORNER_TERMS;
    end else if (ctrl_i.ld_t) begin
      t_q <= t_d;
      k_q <= k_q - 3'd1;
    end
  end

endmodule

### hdl/rwpo_ohlc.sv
// Candle tracker and result register: open/high/low/count and the output stage.
// Depends on rwpo_pkg only by convention; takes the committed price per tick.
module rwpo_ohlc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        commit_i,
  input  logic [31:0] price_i,
  input  logic [7:0]  ticks_per_candle_i,
  input  logic        out_stall_i,
  output logic        out_free_o,
  output logic        out_valid_o,
  output logic [31:0] new_price_o,
  output logic        candle_valid_o,
  output logic [31:0] candle_open_o,
  output logic [31:0] candle_high_o,
  output logic [31:0] candle_low_o,
  output logic [31:0] candle_close_o
);
  import rwpo_pkg::*;

  logic [7:0]  tick_q, cnt_n;
  logic [31:0] open_q, high_q, low_q;
  logic [31:0] open_n, high_n, low_n;
  logic        first, done;
  logic        out_valid_q;

  assign first = (tick_q == 8'd0);
  assign open_n = first ? price_i : open_q;
  assign high_n = (first || price_i > high_q) ? price_i : high_q;
  assign low_n = (first || price_i < low_q) ? price_i : low_q;
  assign cnt_n = tick_q + 8'd1;
  assign done = (cnt_n >= ticks_per_candle_i);

  assign out_free_o = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      open_q <= '0;
      high_q <= '0;
      low_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit_i) begin
        open_q <= open_n;
        high_q <= high_n;
        low_q <= low_n;
        tick_q <= done ? 8'd0 : cnt_n;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        // drop the result once its transfer completes
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i) begin
      new_price_o <= price_i;
      candle_valid_o <= done;
      candle_open_o <= done ? open_n : 32'd0;
      candle_high_o <= done ? high_n : 32'd0;
      candle_low_o <= done ? low_n : 32'd0;
      candle_close_o <= done ? price_i : 32'd0;
    end
  end

endmodule

### hdl/random_walk_price_ohlc_aggregator.sv
// Top level of the random-walk price generator with OHLC candle output.
// Depends on rwpo_pkg, rwpo_sequencer, rwpo_datapath and rwpo_ohlc.
//
// Each accepted sample moves the Q16.16 price by exp(clamp(step_scale * sample))
// and yields one result: the new price plus a candle when the tick count is
// reached. Per tick, from transfer in to the result register: take the sample,
// scale it, clamp, then per term of the six-term exp Horner loop multiply by t,
// divide by k and update t, then one price multiply and a commit, all through a
// single shared multiplier run by the control store. The next sample is taken
// in the idle step after commit; a result still waiting at the output holds
// the commit step. Configuration writes land at once.
module random_walk_price_ohlc_aggregator #(
  parameter int unsigned PRICE_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] normal_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] new_price_o,
  output logic        candle_valid_o,
  output logic [31:0] candle_open_o,
  output logic [31:0] candle_high_o,
  output logic [31:0] candle_low_o,
  output logic [31:0] candle_close_o
);
  import rwpo_pkg::*;

  localparam logic [31:0] PRICE_FLOOR = 32'(((64'd1 << PRICE_FRAC_BITS) + 64'd50) / 64'd100);

  logic [31:0] initial_price_q;
  logic [16:0] step_scale_q;
  logic [7:0]  ticks_per_candle_q;

  ctrl_t      ctrl;
  dp_status_t status;
  logic       out_free;
  logic [31:0] price_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_price_q <= 32'd6553600;
      step_scale_q <= 17'd846;
      ticks_per_candle_q <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INITIAL_PRICE:    initial_price_q <= cfg_wdata_i;
        CFG_STEP_SCALE:       step_scale_q <= cfg_wdata_i[16:0];
        CFG_TICKS_PER_CANDLE: ticks_per_candle_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  rwpo_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  rwpo_datapath #(
    .PRICE_FLOOR (PRICE_FLOOR)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .normal_sample_i (normal_sample_i),
    .initial_price_i (initial_price_q),
    .step_scale_i    (step_scale_q),
    .status_o        (status),
    .price_o         (price_new)
  );

  rwpo_ohlc u_ohlc (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .commit_i           (ctrl.commit),
    .price_i            (price_new),
    .ticks_per_candle_i (ticks_per_candle_q),
    .out_stall_i        (out_stall_i),
    .out_free_o         (out_free),
    .out_valid_o        (out_valid_o),
    .new_price_o        (new_price_o),
    .candle_valid_o     (candle_valid_o),
    .candle_open_o      (candle_open_o),
    .candle_high_o      (candle_high_o),
    .candle_low_o       (candle_low_o),
    .candle_close_o     (candle_close_o)
  );

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |=> out_valid_o)
    else $error("committed tick did not reach the output");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.take_in |-> !ctrl.commit && !ctrl.ld_t && !ctrl.ld_x)
    else $error("sample taken while a tick is in flight");

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> new_price_o >= PRICE_FLOOR)
    else $error("price below floor");

  a_candle_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && candle_valid_o |->
      candle_low_o <= candle_open_o && candle_open_o <= candle_high_o &&
      candle_close_o == new_price_o)
    else $error("candle fields out of order");

  a_no_candle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !candle_valid_o |->
      candle_open_o == 32'd0 && candle_high_o == 32'd0 &&
      candle_low_o == 32'd0 && candle_close_o == 32'd0)
    else $error("candle fields set without a candle");

endmodule

### tb/random_walk_price_ohlc_aggregator_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for random_walk_price_ohlc_aggregator: drives Q4.12 samples,
// predicts every price and candle in a small scoreboard class and checks each transfer.
// Depends on rwpo_pkg and the random_walk_price_ohlc_aggregator top level.
module random_walk_price_ohlc_aggregator_tb;
  import rwpo_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PRINT_CAP = 20;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned EXP_SHIFT = 28;
  localparam longint Q28_ONE = 64'sd268435456;
  localparam longint Q28_HALF = 64'sd134217728;
  localparam longint STEP_CLAMP = 64'sd26843546;
  localparam longint PRICE_MAX = 64'sh0000_0000_FFFF_FFFF;
  localparam longint PRICE_FLOOR = ((64'sd1 << FRAC_BITS) + 64'sd50) / 64'sd100;

  // index past the register list, the block must drop the write
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // first tick is 0 so the initial price below the floor comes back floored
  localparam logic [15:0] OPENING_TICKS [18] = '{
    16'h0000, 16'h7FFF, 16'h8000, 16'h00CC, 16'h00CD, 16'hFF34, 16'hFF33, 16'h0001,
    16'hFFFF, 16'h1000, 16'hF000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF, 16'h8000,
    16'h0000, 16'h0002
  };
  localparam logic [15:0] CORNER_SAMPLES [5] = '{
    16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001
  };

  typedef enum logic [1:0] {WALK_MIXED, WALK_UP, WALK_DOWN} walk_e;
  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_e;

  typedef struct packed {
    logic [31:0] price;
    logic        candle;
    logic [31:0] c_open;
    logic [31:0] c_high;
    logic [31:0] c_low;
    logic [31:0] c_close;
  } tick_result_t;

  class ohlc_book;
    logic [31:0] init_price;
    logic [16:0] step_scale;
    logic [7:0]  candle_len;
    bit          started;
    logic [31:0] price;
    logic [31:0] bar_open;
    logic [31:0] bar_hi;
    logic [31:0] bar_lo;
    logic [7:0]  count;
    tick_result_t expected_ticks[$];
    int unsigned errors;
    int unsigned ticks;
    int unsigned candles;
    int unsigned ceiling_hits;
    int unsigned floor_hits;

    function new();
      init_price = 32'd6553600;
      step_scale = 17'd846;
      candle_len = 8'd10;
      started = 1'b0;
      price = '0;
      bar_open = '0;
      bar_hi = '0;
      bar_lo = '0;
      count = '0;
      errors = 0;
      ticks = 0;
      candles = 0;
      ceiling_hits = 0;
      floor_hits = 0;
    endfunction

    function int unsigned outstanding();
      return expected_ticks.size();
    endfunction

    function void apply_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_INITIAL_PRICE:    init_price = val;
        CFG_STEP_SCALE:       step_scale = val[16:0];
        CFG_TICKS_PER_CANDLE: candle_len = val[7:0];
        default: ;
      endcase
    endfunction

    // degree-6 Horner series of exp in Q.28, floor on the shift, truncating divide
    function longint exp_horner(longint x);
      longint t;
      t = Q28_ONE;
      for (int k = 6; k >= 1; k--)
        t = Q28_ONE + ((x * t) >>> EXP_SHIFT) / k;
      return t;
    endfunction

    function void take_sample(logic [15:0] s);
      longint x;
      longint e;
      longint p;
      tick_result_t r;
      if (!started) begin
        price = init_price;
        started = 1'b1;
      end
      x = longint'(step_scale) * longint'($signed(s));
      if (x > STEP_CLAMP) x = STEP_CLAMP;
      else if (x < -STEP_CLAMP) x = -STEP_CLAMP;
      e = exp_horner(x);
      p = (longint'(price) * e + Q28_HALF) >>> EXP_SHIFT;
      if (p > PRICE_MAX) begin
        p = PRICE_MAX;
        ceiling_hits++;
      end
      if (p < PRICE_FLOOR) begin
        p = PRICE_FLOOR;
        floor_hits++;
      end
      price = p[31:0];
      if (count == 8'd0) begin
        bar_open = price;
        bar_hi = price;
        bar_lo = price;
      end else begin
        if (price > bar_hi) bar_hi = price;
        if (price < bar_lo) bar_lo = price;
      end
      count = count + 8'd1;
      r = '0;
      r.price = price;
      if (count >= candle_len) begin
        r.candle = 1'b1;
        r.c_open = bar_open;
        r.c_high = bar_hi;
        r.c_low = bar_lo;
        r.c_close = price;
        count = '0;
        candles++;
      end
      ticks++;
      expected_ticks.insert(expected_ticks.size(), r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("%0t mismatch: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h, want %h", name, got, want));
    endtask

    task check_result(tick_result_t got);
      tick_result_t want;
      if (expected_ticks.size() == 0) begin
        report($sformatf("result with nothing pending, price %h", got.price));
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("new_price", got.price, want.price);
      compare_field("candle_valid", 32'(got.candle), 32'(want.candle));
      compare_field("candle_open", got.c_open, want.c_open);
      compare_field("candle_high", got.c_high, want.c_high);
      compare_field("candle_low", got.c_low, want.c_low);
      compare_field("candle_close", got.c_close, want.c_close);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] normal_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] new_price_o;
  logic        candle_valid_o;
  logic [31:0] candle_open_o;
  logic [31:0] candle_high_o;
  logic [31:0] candle_low_o;
  logic [31:0] candle_close_o;

  ohlc_book    price_book;
  int unsigned cycle_count = 0;
  int unsigned stall_cycle = 0;
  stall_e      stall_mode = STALL_NONE;

  random_walk_price_ohlc_aggregator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .normal_sample_i(normal_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_price_o    (new_price_o),
    .candle_valid_o (candle_valid_o),
    .candle_open_o  (candle_open_o),
    .candle_high_o  (candle_high_o),
    .candle_low_o   (candle_low_o),
    .candle_close_o (candle_close_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stall pattern, switching among four styles at random
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 97 == 0) stall_mode <= stall_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     out_stall_i <= 1'b0;
      STALL_COIN:     out_stall_i <= ($urandom_range(0, 1) == 0);
      STALL_PERIODIC: out_stall_i <= (stall_cycle % 5 < 2);
      default:        out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    tick_result_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{new_price_o, candle_valid_o, candle_open_o, candle_high_o,
               candle_low_o, candle_close_o};
      price_book.check_result(seen);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("run stalled after %0d cycles", cycle_count);
    $display("[random_walk_price_ohlc_aggregator] ERROR");
    $finish;
  end

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    price_book.apply_reg(idx, val);
  endtask

  task automatic send_sample(input logic [15:0] s);
    in_valid_i <= 1'b1;
    normal_sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    price_book.take_sample(s);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (price_book.outstanding() != 0);
  endtask

  function automatic logic [15:0] pick_sample(walk_e walk);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    // with the largest step scale these always hit the clamp, with random content
    if (walk == WALK_UP && mode != 0) return 16'($urandom_range(205, 32767));
    if (walk == WALK_DOWN && mode != 0) return 16'(0 - int'($urandom_range(205, 32768)));
    case (mode)
      0, 1, 2, 3:
        return 16'(int'($urandom_range(0, 8191)) + int'($urandom_range(0, 8191))
                   + int'($urandom_range(0, 8191)) + int'($urandom_range(0, 8191)) - 16382);
      4, 5: return 16'($urandom);
      6: return 16'(int'($urandom_range(0, 600)) - 300);
      7: return CORNER_SAMPLES[$urandom_range(0, 4)];
      default: return 16'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic run_ticks(input int unsigned n, input walk_e walk);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
      for (int unsigned b = 0; b < burst && sent < n; b++) begin
        send_sample(pick_sample(walk));
        sent++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (sent < n && $urandom_range(0, 29) == 0) begin
        // hold off until the pipeline is empty
        in_valid_i <= 1'b0;
        wait_drained();
      end else if (sent < n && gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  initial begin
    logic [7:0] len;
    price_book = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // the second initial price wins; it is below the floor
    write_reg(CFG_INITIAL_PRICE, 32'hFFFF_FFFF);
    write_reg(CFG_INITIAL_PRICE, 32'd300);
    write_reg(CFG_STEP_SCALE, 32'h0001_FFFF);
    write_reg(CFG_UNUSED, $urandom);
    write_reg(CFG_TICKS_PER_CANDLE, 32'd4);
    cfg_we_i <= 1'b0;
    foreach (OPENING_TICKS[i]) begin
      send_sample(OPENING_TICKS[i]);
      if (i % 5 == 4) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    wait_drained();

    // zero scale with junk above bit 16, zero candle length: flat price, candle per tick
    write_reg(CFG_STEP_SCALE, 32'hFFFE_0000);
    write_reg(CFG_TICKS_PER_CANDLE, 32'd0);
    cfg_we_i <= 1'b0;
    run_ticks(30, WALK_MIXED);

    write_reg(CFG_STEP_SCALE, 32'd846);
    write_reg(CFG_TICKS_PER_CANDLE, 32'd10);
    cfg_we_i <= 1'b0;
    run_ticks(100, WALK_MIXED);

    // climb into saturation; the late initial price must not take effect
    write_reg(CFG_INITIAL_PRICE, 32'd1);
    write_reg(CFG_STEP_SCALE, 32'h0001_FFFF);
    write_reg(CFG_TICKS_PER_CANDLE, 32'd255);
    cfg_we_i <= 1'b0;
    run_ticks(260, WALK_UP);

    // candle length below the running count, then fall to the floor
    write_reg(CFG_TICKS_PER_CANDLE, 32'hFFFF_FF03);
    cfg_we_i <= 1'b0;
    run_ticks(200, WALK_DOWN);

    for (int ph = 0; ph < 4; ph++) begin
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_STEP_SCALE, {15'($urandom), 17'($urandom_range(0, 131071))});
      else
        write_reg(CFG_STEP_SCALE, {15'($urandom), 17'($urandom_range(0, 4000))});
      case ($urandom_range(0, 3))
        0: len = 8'd1;
        1: len = 8'd0;
        default: len = 8'($urandom_range(2, 12));
      endcase
      write_reg(CFG_TICKS_PER_CANDLE, {24'($urandom), len});
      cfg_we_i <= 1'b0;
      run_ticks(30, WALK_MIXED);
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (price_book.outstanding() != 0)
      price_book.report($sformatf("%0d results never arrived", price_book.outstanding()));

    $display("ran %0d ticks into %0d candles over %0d cycles", price_book.ticks,
             price_book.candles, cycle_count);
    $display("price held at the ceiling %0d times and at the floor %0d times",
             price_book.ceiling_hits, price_book.floor_hits);
    if (price_book.errors == 0) begin
      $display("[random_walk_price_ohlc_aggregator] OK");
    end else begin
      $display("%0d mismatches", price_book.errors);
      $display("[random_walk_price_ohlc_aggregator] ERROR");
    end
    $finish;
  end

endmodule
